FILE: rtl/core/first_fit_block_table_allocator_top_macros.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects the including module to have aclk and aresetn in scope.
`ifndef FIRST_FIT_BLOCK_TABLE_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_TABLE_ALLOCATOR_TOP_MACROS_SVH

// Checks a property on every rising edge of aclk outside reset.
`define FFBTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define FFBTA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

FILE: rtl/core/ffbta_pkg.sv
// Package for the first-fit block table allocator: sizes, codes and types.
// Used by every module in rtl/core; depends on nothing.
package ffbta_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ALIGN_MAX     = 16;

    localparam logic [31:0] REGION_BYTES_RESET = 32'h0010_0000;
    localparam logic [4:0]  ALIGN_LOG2_RESET   = 5'd12;

    localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [1:0] CFG_REGION_BYTES = 2'd1;
    localparam logic [1:0] CFG_ALIGN_LOG2   = 2'd2;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_MERGE = 2'd3;

    localparam logic [1:0] AK_STRING = 2'd1;
    localparam logic [1:0] AK_ARRAY  = 2'd2;

    localparam logic [2:0] KIND_UNUSED = 3'd0;
    localparam logic [2:0] KIND_FREE   = 3'd1;
    localparam logic [2:0] KIND_OBJECT = 3'd2;
    localparam logic [2:0] KIND_STRING = 3'd3;
    localparam logic [2:0] KIND_ARRAY  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ALLOC_SCAN,
        S_ALLOC_SLOT,
        S_ALLOC_FIT,
        S_FREE_SCAN,
        S_FREE_WR,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_SCAN,
        S_MERGE_JOIN,
        S_SUM,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [2:0]  kind;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] request_bytes;
        logic [1:0]  alloc_kind;
        logic [31:0] release_addr;
    } cmd_t;

    typedef struct packed {
        logic [31:0] region_base;
        logic [31:0] region_bytes;
        logic [4:0]  align_log2;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] block_addr;
        logic [7:0]  joins_done;
        logic [31:0] bytes_in_use;
        logic [6:0]  entries_in_use;
    } res_t;

endpackage

FILE: rtl/core/ffbta_table_ram.sv
// Entry table storage: one write port, one read port, registered read data.
// Depends on ffbta_pkg for the depth and the entry layout.
module ffbta_table_ram (
    input  logic                aclk,
    input  ffbta_pkg::ram_req_t req,
    output ffbta_pkg::entry_t   rd_data
);

    ffbta_pkg::entry_t mem [ffbta_pkg::TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: rtl/core/ffbta_engine.sv
// Operation sequencer: scans the entry table one entry a cycle and writes entries back.
// Depends on ffbta_pkg and on the macro header; drives ffbta_table_ram.
`include "first_fit_block_table_allocator_top_macros.svh"

module ffbta_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  ffbta_pkg::cmd_t     cmd,
    input  ffbta_pkg::cfg_t     cfg,
    input  logic                out_ready,
    output logic                idle,
    output logic                done,
    output ffbta_pkg::res_t     res,
    output ffbta_pkg::ram_req_t ram_req,
    input  ffbta_pkg::entry_t   ram_rdata
);

    localparam int IW = ffbta_pkg::IDX_W;
    localparam int CW = ffbta_pkg::CNT_W;
    localparam logic [CW-1:0] N_ENT = CW'(ffbta_pkg::TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST  = IW'(ffbta_pkg::TABLE_ENTRIES - 1);

    ffbta_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [31:0]   size_reg, size_next;
    logic [2:0]    kind_reg, kind_next;
    logic [31:0]   rel_reg, rel_next;
    logic          fit_found_reg, fit_found_next;
    logic [IW-1:0] fit_idx_reg, fit_idx_next;
    logic [31:0]   fit_start_reg, fit_start_next;
    logic [31:0]   fit_len_reg, fit_len_next;
    logic          slot_found_reg, slot_found_next;
    logic [IW-1:0] slot_idx_reg, slot_idx_next;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   addr_reg, addr_next;
    logic [7:0]    joins_reg, joins_next;
    logic [CW-1:0] ventries_reg, ventries_next;
    logic [31:0]   acc_reg, acc_next;
    logic [CW-1:0] e_idx_reg, e_idx_next;
    logic [31:0]   e_start_reg, e_start_next;
    logic [31:0]   e_len_reg, e_len_next;
    logic [IW-1:0] j_idx_reg, j_idx_next;
    logic [ffbta_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;

    ffbta_pkg::entry_t rd_e;
    logic [4:0]    shift;
    logic [32:0]   mask33, size33;
    logic [2:0]    kind_map;
    logic          rd_last, cnt_live, e_last, scan_state, join_state;
    logic [IW-1:0] e_sel;
    logic          fit_hit, slot_hit, fit_any, slot_any, free_hit, join_hit, touch;
    logic [32:0]   end_e, end_j, len_sum, acc_sum;

    // An entry whose valid bit is clear reads as unused with zero fields.
    assign rd_e = rd_valid_reg ? ram_rdata : '0;

    assign shift  = (cfg.align_log2 > 5'(ffbta_pkg::ALIGN_MAX)) ?
                    5'(ffbta_pkg::ALIGN_MAX) : cfg.align_log2;
    assign mask33 = (33'd1 << shift) - 33'd1;
    assign size33 = ({1'b0, cmd.request_bytes} + mask33) & ~mask33;

    always_comb begin
        case (cmd.alloc_kind)
            ffbta_pkg::AK_STRING: kind_map = ffbta_pkg::KIND_STRING;
            ffbta_pkg::AK_ARRAY:  kind_map = ffbta_pkg::KIND_ARRAY;
            default:              kind_map = ffbta_pkg::KIND_OBJECT;
        endcase
    end

    assign rd_last  = rd_vld_reg && (rd_idx_reg == LAST);
    assign cnt_live = cnt_reg < N_ENT;
    assign e_last   = e_idx_reg == N_ENT;
    // The extra pass after the last entry visits entry zero once more.
    assign e_sel    = e_last ? '0 : e_idx_reg[IW-1:0];

    assign fit_hit  = rd_vld_reg && !fit_found_reg && (rd_e.kind == ffbta_pkg::KIND_FREE) &&
                      (rd_e.length >= size_reg);
    assign slot_hit = rd_vld_reg && !slot_found_reg && (rd_e.kind == ffbta_pkg::KIND_UNUSED);
    assign fit_any  = fit_found_reg || fit_hit;
    assign slot_any = slot_found_reg || slot_hit;
    assign free_hit = rd_vld_reg && (rd_e.kind > ffbta_pkg::KIND_FREE) &&
                      (rd_e.start == rel_reg);

    assign end_e    = {1'b0, e_start_reg} + {1'b0, e_len_reg};
    assign end_j    = {1'b0, rd_e.start} + {1'b0, rd_e.length};
    assign touch    = (end_j == {1'b0, e_start_reg}) || (end_e == {1'b0, rd_e.start});
    assign join_hit = rd_vld_reg && (rd_idx_reg != e_sel) &&
                      (rd_e.kind == ffbta_pkg::KIND_FREE) && touch;
    assign len_sum  = {1'b0, e_len_reg} + {1'b0, rd_e.length};
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, rd_e.length};

    assign scan_state = (state_reg == ffbta_pkg::S_ALLOC_SCAN) ||
                        (state_reg == ffbta_pkg::S_FREE_SCAN)  ||
                        (state_reg == ffbta_pkg::S_MERGE_SCAN) ||
                        (state_reg == ffbta_pkg::S_SUM);
    assign join_state = state_reg == ffbta_pkg::S_MERGE_JOIN;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffbta_pkg::S_IDLE: begin
                if (start) begin
                    unique case (cmd.op)
                        ffbta_pkg::OP_INIT:  state_next = ffbta_pkg::S_INIT;
                        ffbta_pkg::OP_ALLOC: begin
                            if ((cmd.request_bytes == '0) || size33[32]) begin
                                state_next = ffbta_pkg::S_SUM;
                            end else begin
                                state_next = ffbta_pkg::S_ALLOC_SCAN;
                            end
                        end
                        ffbta_pkg::OP_FREE:  state_next = ffbta_pkg::S_FREE_SCAN;
                        default:             state_next = ffbta_pkg::S_MERGE_RD;
                    endcase
                end
            end
            ffbta_pkg::S_INIT: state_next = ffbta_pkg::S_SUM;
            ffbta_pkg::S_ALLOC_SCAN: begin
                if (rd_last) begin
                    state_next = (fit_any && slot_any) ? ffbta_pkg::S_ALLOC_SLOT :
                                                         ffbta_pkg::S_SUM;
                end
            end
            ffbta_pkg::S_ALLOC_SLOT: state_next = ffbta_pkg::S_ALLOC_FIT;
            ffbta_pkg::S_ALLOC_FIT:  state_next = ffbta_pkg::S_SUM;
            ffbta_pkg::S_FREE_SCAN: begin
                if (free_hit) begin
                    state_next = ffbta_pkg::S_FREE_WR;
                end else if (rd_last) begin
                    state_next = ffbta_pkg::S_SUM;
                end
            end
            ffbta_pkg::S_FREE_WR:  state_next = ffbta_pkg::S_SUM;
            ffbta_pkg::S_MERGE_RD: state_next = ffbta_pkg::S_MERGE_CHK;
            ffbta_pkg::S_MERGE_CHK: begin
                if (rd_e.kind == ffbta_pkg::KIND_FREE) begin
                    state_next = ffbta_pkg::S_MERGE_SCAN;
                end else begin
                    state_next = e_last ? ffbta_pkg::S_SUM : ffbta_pkg::S_MERGE_RD;
                end
            end
            ffbta_pkg::S_MERGE_SCAN: begin
                if (join_hit) begin
                    state_next = ffbta_pkg::S_MERGE_JOIN;
                end else if (rd_last) begin
                    state_next = e_last ? ffbta_pkg::S_SUM : ffbta_pkg::S_MERGE_RD;
                end
            end
            ffbta_pkg::S_MERGE_JOIN: begin
                state_next = e_last ? ffbta_pkg::S_SUM : ffbta_pkg::S_MERGE_RD;
            end
            ffbta_pkg::S_SUM: begin
                if (rd_last) begin
                    state_next = ffbta_pkg::S_DONE;
                end
            end
            ffbta_pkg::S_DONE: begin
                if (out_ready) begin
                    state_next = ffbta_pkg::S_IDLE;
                end
            end
            default: state_next = ffbta_pkg::S_IDLE;
        endcase
    end

    // Memory accesses and datapath updates.
    always_comb begin
        ram_req         = '0;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        rd_valid_next   = rd_valid_reg;
        size_next       = size_reg;
        kind_next       = kind_reg;
        rel_next        = rel_reg;
        fit_found_next  = fit_found_reg;
        fit_idx_next    = fit_idx_reg;
        fit_start_next  = fit_start_reg;
        fit_len_next    = fit_len_reg;
        slot_found_next = slot_found_reg;
        slot_idx_next   = slot_idx_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        joins_next      = joins_reg;
        ventries_next   = ventries_reg;
        acc_next        = acc_reg;
        e_idx_next      = e_idx_reg;
        e_start_next    = e_start_reg;
        e_len_next      = e_len_reg;
        j_idx_next      = j_idx_reg;
        valid_next      = valid_reg;

        if (scan_state && cnt_live) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = cnt_reg[IW-1:0];
            cnt_next        = cnt_reg + CW'(1);
        end
        if (state_reg == ffbta_pkg::S_MERGE_RD) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = e_sel;
        end

        unique case (state_reg)
            ffbta_pkg::S_IDLE: begin
                if (start) begin
                    status_next     = ffbta_pkg::ST_OK;
                    addr_next       = '0;
                    joins_next      = '0;
                    size_next       = size33[31:0];
                    kind_next       = kind_map;
                    rel_next        = cmd.release_addr;
                    fit_found_next  = 1'b0;
                    slot_found_next = 1'b0;
                    e_idx_next      = '0;
                    if (cmd.op == ffbta_pkg::OP_ALLOC) begin
                        if (cmd.request_bytes == '0) begin
                            status_next = ffbta_pkg::ST_ZERO;
                        end else if (size33[32]) begin
                            status_next = ffbta_pkg::ST_NOFIT;
                        end
                    end
                end
            end
            ffbta_pkg::S_INIT: begin
                valid_next    = '0;
                ventries_next = '0;
                if (cfg.region_bytes != '0) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = '0;
                    ram_req.wr_data = '{cfg.region_base, cfg.region_bytes,
                                        ffbta_pkg::KIND_FREE};
                    valid_next[0]   = 1'b1;
                    ventries_next   = CW'(1);
                end
            end
            ffbta_pkg::S_ALLOC_SCAN: begin
                if (fit_hit) begin
                    fit_found_next = 1'b1;
                    fit_idx_next   = rd_idx_reg;
                    fit_start_next = rd_e.start;
                    fit_len_next   = rd_e.length;
                end
                if (slot_hit) begin
                    slot_found_next = 1'b1;
                    slot_idx_next   = rd_idx_reg;
                end
                if (rd_last && !fit_any) begin
                    status_next = ffbta_pkg::ST_NOFIT;
                end else if (rd_last && !slot_any) begin
                    status_next = ffbta_pkg::ST_FULL;
                end
            end
            ffbta_pkg::S_ALLOC_SLOT: begin
                ram_req.wr_en             = 1'b1;
                ram_req.wr_addr           = slot_idx_reg;
                ram_req.wr_data           = '{fit_start_reg, size_reg, kind_reg};
                valid_next[slot_idx_reg]  = 1'b1;
                ventries_next             = ventries_reg + CW'(1);
                addr_next                 = fit_start_reg;
            end
            ffbta_pkg::S_ALLOC_FIT: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = fit_idx_reg;
                ram_req.wr_data = '{fit_start_reg + size_reg, fit_len_reg - size_reg,
                                    ffbta_pkg::KIND_FREE};
            end
            ffbta_pkg::S_FREE_SCAN: begin
                if (free_hit) begin
                    j_idx_next   = rd_idx_reg;
                    e_start_next = rd_e.start;
                    e_len_next   = rd_e.length;
                end else if (rd_last) begin
                    status_next = ffbta_pkg::ST_NOTFOUND;
                end
            end
            ffbta_pkg::S_FREE_WR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = j_idx_reg;
                ram_req.wr_data = '{e_start_reg, e_len_reg, ffbta_pkg::KIND_FREE};
            end
            ffbta_pkg::S_MERGE_RD: begin
            end
            ffbta_pkg::S_MERGE_CHK: begin
                if (rd_e.kind == ffbta_pkg::KIND_FREE) begin
                    e_start_next = rd_e.start;
                    e_len_next   = rd_e.length;
                end else if (!e_last) begin
                    e_idx_next = e_idx_reg + CW'(1);
                end
            end
            ffbta_pkg::S_MERGE_SCAN: begin
                if (join_hit) begin
                    j_idx_next   = rd_idx_reg;
                    e_start_next = (e_start_reg > rd_e.start) ? rd_e.start : e_start_reg;
                    e_len_next   = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
                end else if (rd_last && !e_last) begin
                    e_idx_next = e_idx_reg + CW'(1);
                end
            end
            ffbta_pkg::S_MERGE_JOIN: begin
                ram_req.wr_en         = 1'b1;
                ram_req.wr_addr       = e_sel;
                ram_req.wr_data       = '{e_start_reg, e_len_reg, ffbta_pkg::KIND_FREE};
                // Clearing the valid bit is enough to make the partner read as unused.
                valid_next[j_idx_reg] = 1'b0;
                if (joins_reg != 8'hFF) begin
                    joins_next = joins_reg + 8'd1;
                end
                if (ventries_reg != '0) begin
                    ventries_next = ventries_reg - CW'(1);
                end
                if (!e_last) begin
                    e_idx_next = e_idx_reg + CW'(1);
                end
            end
            ffbta_pkg::S_SUM: begin
                if (rd_vld_reg && (rd_e.kind > ffbta_pkg::KIND_FREE)) begin
                    acc_next = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                end
            end
            ffbta_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase

        if (ram_req.rd_en) begin
            rd_idx_next   = ram_req.rd_addr;
            rd_valid_next = valid_reg[ram_req.rd_addr];
        end
        // Data of a read issued in the last cycle of a scan is dropped.
        rd_vld_next = ram_req.rd_en && scan_state && (state_next == state_reg);
        if (state_next != state_reg) begin
            cnt_next = '0;
        end
        if ((state_next == ffbta_pkg::S_SUM) && (state_reg != ffbta_pkg::S_SUM)) begin
            acc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ffbta_pkg::S_IDLE;
            rd_vld_reg   <= 1'b0;
            valid_reg    <= '0;
            ventries_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            valid_reg    <= valid_next;
            ventries_reg <= ventries_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        rd_valid_reg   <= rd_valid_next;
        size_reg       <= size_next;
        kind_reg       <= kind_next;
        rel_reg        <= rel_next;
        fit_found_reg  <= fit_found_next;
        fit_idx_reg    <= fit_idx_next;
        fit_start_reg  <= fit_start_next;
        fit_len_reg    <= fit_len_next;
        slot_found_reg <= slot_found_next;
        slot_idx_reg   <= slot_idx_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        joins_reg      <= joins_next;
        acc_reg        <= acc_next;
        e_idx_reg      <= e_idx_next;
        e_start_reg    <= e_start_next;
        e_len_reg      <= e_len_next;
        j_idx_reg      <= j_idx_next;
    end

    assign idle = state_reg == ffbta_pkg::S_IDLE;
    assign done = state_reg == ffbta_pkg::S_DONE;

    assign res.status         = status_reg;
    assign res.block_addr     = addr_reg;
    assign res.joins_done     = joins_reg;
    assign res.bytes_in_use   = acc_reg;
    assign res.entries_in_use = (32'(ventries_reg) > 32'd127) ? 7'd127 : 7'(ventries_reg);

    `FFBTA_ASSERT(a_entry_count, ventries_reg <= N_ENT, "entry count exceeds table size")
    `FFBTA_NEVER(a_rw_overlap, ram_req.rd_en && ram_req.wr_en, "table read and write overlap")
    `FFBTA_NEVER(a_self_join, join_state && (j_idx_reg == e_sel), "entry joined with itself")
    `FFBTA_ASSERT(a_done_exit, done |=> (done || idle), "result state left for a busy state")

endmodule

FILE: rtl/core/first_fit_block_table_allocator_top.sv
// Top level of the first-fit block table allocator: ports, configuration, result register.
// Depends on ffbta_pkg, ffbta_engine and ffbta_table_ram.
//
// Usage: an operation (init, allocate, free, merge) arrives on the s_ channel as one
// transaction and yields exactly one result transaction on the m_ channel.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while the block is idle, which the block does not enforce; region_base
// is index 0, region_bytes 1, align_log2 2. Every operation ends with a pass over the
// table that totals the bytes in use, one entry a cycle through the single read port of
// the table memory. Before it, init writes a nonempty region entry; allocate scans the
// full table and makes two write-backs when a fit and an unused slot exist; free writes
// back the block it finds as free; merge runs one partner scan per free entry it visits.
// One operation is in flight at a time; s_ready is high only while the sequencer idles.
// A finished result sits in the output register while the next operation is accepted;
// if the receiver stalls, the sequencer holds its result until the register frees.
// Reset empties the table (all entries unused) and loads the configuration defaults.
module first_fit_block_table_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_request_bytes,
    input  logic [1:0]  s_alloc_kind,
    input  logic [31:0] s_release_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_block_addr,
    output logic [7:0]  m_joins_done,
    output logic [31:0] m_bytes_in_use,
    output logic [6:0]  m_entries_in_use
);

    ffbta_pkg::cfg_t     cfg_reg;
    ffbta_pkg::cmd_t     cmd;
    ffbta_pkg::res_t     res;
    ffbta_pkg::res_t     out_reg;
    ffbta_pkg::ram_req_t ram_req;
    ffbta_pkg::entry_t   ram_rdata;
    logic                m_valid_reg;
    logic                eng_idle, eng_done, out_ready, load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.region_base  <= '0;
            cfg_reg.region_bytes <= ffbta_pkg::REGION_BYTES_RESET;
            cfg_reg.align_log2   <= ffbta_pkg::ALIGN_LOG2_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                ffbta_pkg::CFG_REGION_BASE:  cfg_reg.region_base  <= cfg_wdata;
                ffbta_pkg::CFG_REGION_BYTES: cfg_reg.region_bytes <= cfg_wdata;
                ffbta_pkg::CFG_ALIGN_LOG2:   cfg_reg.align_log2   <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    assign cmd = '{s_op, s_request_bytes, s_alloc_kind, s_release_addr};

    assign s_ready   = eng_idle;
    assign out_ready = !m_valid_reg || m_ready;
    assign load_out  = eng_done && out_ready;

    ffbta_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && eng_idle),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .out_ready (out_ready),
        .idle      (eng_idle),
        .done      (eng_done),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    ffbta_table_ram u_table (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_block_addr     = out_reg.block_addr;
    assign m_joins_done     = out_reg.joins_done;
    assign m_bytes_in_use   = out_reg.bytes_in_use;
    assign m_entries_in_use = out_reg.entries_in_use;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for first_fit_block_table_allocator_top.
// Depends on ffbta_pkg; predicts each result from its own copy of the entry table.
`timescale 1ns / 1ps

module tb;
    import ffbta_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          WATCHDOG    = 40000;
    localparam logic [1:0]  AK_OBJECT   = 2'd0;
    localparam logic [1:0]  AK_SPARE    = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] request_bytes;
        logic [1:0]  alloc_kind;
        logic [31:0] release_addr;
        bit          pick_live;
    } op_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = CFG_REGION_BASE;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_INIT;
    logic [31:0] s_request_bytes = '0;
    logic [1:0]  s_alloc_kind = AK_OBJECT;
    logic [31:0] s_release_addr = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_block_addr;
    logic [7:0]  m_joins_done;
    logic [31:0] m_bytes_in_use;
    logic [6:0]  m_entries_in_use;

    first_fit_block_table_allocator_top dut (.*);

    always #HALF_PERIOD aclk = ~aclk;

    // Shadow of the block's configuration and heap table.
    logic [31:0] shadow_base = 32'd0;
    logic [31:0] shadow_bytes = REGION_BYTES_RESET;
    logic [4:0]  shadow_align = ALIGN_LOG2_RESET;
    logic [31:0] heap_start [TABLE_ENTRIES];
    logic [31:0] heap_len [TABLE_ENTRIES];
    logic [2:0]  heap_kind [TABLE_ENTRIES];
    int unsigned heap_count;

    op_item_t pending_ops[$];
    res_t     expected_results[$];
    bit       steady = 1'b0;
    int       fail_count = 0;
    int       quiet_cycles = 0;

    function automatic void wipe_heap();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            heap_start[i] = '0;
            heap_len[i] = '0;
            heap_kind[i] = KIND_UNUSED;
        end
        heap_count = 0;
    endfunction

    // Joins entry e with its first free neighbor; ends are taken without wrap.
    function automatic int join_neighbor(int e);
        logic [32:0] end_e, end_j;
        logic [32:0] total;
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (j == e || heap_kind[j] != KIND_FREE) continue;
            end_e = {1'b0, heap_start[e]} + heap_len[e];
            end_j = {1'b0, heap_start[j]} + heap_len[j];
            if (end_j != {1'b0, heap_start[e]} && end_e != {1'b0, heap_start[j]}) continue;
            if (heap_start[e] > heap_start[j]) heap_start[e] = heap_start[j];
            total = {1'b0, heap_len[e]} + heap_len[j];
            heap_len[e] = total[32] ? 32'hFFFF_FFFF : total[31:0];
            heap_start[j] = '0;
            heap_len[j] = '0;
            heap_kind[j] = KIND_UNUSED;
            if (heap_count > 0) heap_count--;
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [2:0] carve_block(logic [31:0] req, logic [1:0] kind_in,
                                               output logic [31:0] addr);
        int sh, fit, slot;
        logic [63:0] gran, rounded;
        addr = '0;
        if (req == 0) return ST_ZERO;
        sh = (shadow_align > ALIGN_MAX) ? ALIGN_MAX : int'(shadow_align);
        gran = 64'd1 << sh;
        rounded = ({32'd0, req} + gran - 64'd1) & ~(gran - 64'd1);
        if (rounded > 64'hFFFF_FFFF) return ST_NOFIT;
        fit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (fit < 0 && heap_kind[i] == KIND_FREE && {32'd0, heap_len[i]} >= rounded) fit = i;
        if (fit < 0) return ST_NOFIT;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && heap_kind[i] == KIND_UNUSED) slot = i;
        if (slot < 0) return ST_FULL;
        heap_start[slot] = heap_start[fit];
        heap_len[slot] = rounded[31:0];
        heap_kind[slot] = (kind_in == AK_STRING) ? KIND_STRING :
                          (kind_in == AK_ARRAY) ? KIND_ARRAY : KIND_OBJECT;
        heap_count++;
        addr = heap_start[fit];
        heap_start[fit] = heap_start[fit] + rounded[31:0];
        heap_len[fit] = heap_len[fit] - rounded[31:0];
        return ST_OK;
    endfunction

    function automatic res_t predict_result(logic [1:0] op, logic [31:0] req,
                                            logic [1:0] kind_in, logic [31:0] rel);
        res_t r;
        int unsigned joins;
        logic [63:0] used;
        r = '0;
        joins = 0;
        case (op)
            OP_INIT: begin
                wipe_heap();
                if (shadow_bytes != 0) begin
                    heap_start[0] = shadow_base;
                    heap_len[0] = shadow_bytes;
                    heap_kind[0] = KIND_FREE;
                    heap_count = 1;
                end
            end
            OP_ALLOC: r.status = carve_block(req, kind_in, r.block_addr);
            OP_FREE: begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (heap_start[i] == rel && heap_kind[i] > KIND_FREE) begin
                        heap_kind[i] = KIND_FREE;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            default: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (heap_kind[i] == KIND_FREE) joins += join_neighbor(i);
                if (heap_kind[0] == KIND_FREE) joins += join_neighbor(0);
                r.joins_done = (joins > 255) ? 8'd255 : joins[7:0];
            end
        endcase
        used = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (heap_kind[i] > KIND_FREE) used += heap_len[i];
        r.bytes_in_use = (used > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : used[31:0];
        r.entries_in_use = (heap_count > 127) ? 7'd127 : heap_count[6:0];
        return r;
    endfunction

    function automatic logic [31:0] live_block_addr();
        int used_idx[$];
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (heap_kind[i] > KIND_FREE) used_idx.push_back(i);
        if (used_idx.size() == 0) return $urandom;
        return heap_start[used_idx[$urandom_range(0, used_idx.size() - 1)]];
    endfunction

    // Driver: predicts each accepted transaction, then presents the next one.
    always @(posedge aclk) begin
        op_item_t nxt;
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_op, s_request_bytes,
                                                           s_alloc_kind, s_release_addr));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_ops.size() > 0 &&
                (steady || $urandom_range(0, 99) >= 32)) begin
                nxt = pending_ops.pop_front();
                s_op <= nxt.op;
                s_request_bytes <= nxt.request_bytes;
                s_alloc_kind <= nxt.alloc_kind;
                s_release_addr <= nxt.pick_live ? live_block_addr() : nxt.release_addr;
                next_valid = 1'b1;
            end
            s_valid <= next_valid;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 32);
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_block_addr !== want.block_addr) begin
                    $error("block_addr expected %h got %h", want.block_addr, m_block_addr);
                    fail_count++;
                end
                if (m_joins_done !== want.joins_done) begin
                    $error("joins_done expected %0d got %0d", want.joins_done, m_joins_done);
                    fail_count++;
                end
                if (m_bytes_in_use !== want.bytes_in_use) begin
                    $error("bytes_in_use expected %h got %h", want.bytes_in_use,
                           m_bytes_in_use);
                    fail_count++;
                end
                if (m_entries_in_use !== want.entries_in_use) begin
                    $error("entries_in_use expected %0d got %0d", want.entries_in_use,
                           m_entries_in_use);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: only counts while work is outstanding and nothing moves.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (pending_ops.size() > 0 || s_valid || expected_results.size() > 0) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_op(logic [1:0] op, logic [31:0] req = 0,
                            logic [1:0] kind = AK_OBJECT, logic [31:0] rel = 0,
                            bit live = 1'b0);
        op_item_t it;
        it.op = op;
        it.request_bytes = req;
        it.alloc_kind = kind;
        it.release_addr = rel;
        it.pick_live = live;
        pending_ops.push_back(it);
    endtask

    task automatic queue_random_ops(int count);
        int sh, roll;
        logic [31:0] req;
        sh = (shadow_align > ALIGN_MAX) ? ALIGN_MAX : int'(shadow_align);
        queue_op(OP_INIT);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                req = $urandom_range(1, 8 << sh);
                if ($urandom_range(0, 9) == 0) req = $urandom;
                else if ($urandom_range(0, 19) == 0) req = 0;
                queue_op(OP_ALLOC, req, 2'($urandom_range(0, 3)), $urandom);
            end else if (roll < 82) begin
                queue_op(OP_FREE, $urandom, 2'($urandom_range(0, 3)), 0, 1'b1);
            end else if (roll < 88) begin
                queue_op(OP_FREE, $urandom, 2'($urandom_range(0, 3)), $urandom);
            end else if (roll < 97) begin
                queue_op(OP_MERGE, $urandom, 2'($urandom_range(0, 3)), $urandom);
            end else begin
                queue_op(OP_INIT, $urandom, 2'($urandom_range(0, 3)), $urandom);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_REGION_BASE:  shadow_base = value;
            CFG_REGION_BYTES: shadow_bytes = value;
            default:          shadow_align = value[4:0];
        endcase
    endtask

    task automatic run_phase(logic [31:0] base, logic [31:0] bytes, logic [4:0] align,
                             int count);
        write_reg(CFG_REGION_BASE, base);
        write_reg(CFG_REGION_BYTES, bytes);
        write_reg(CFG_ALIGN_LOG2, {27'd0, align});
        queue_random_ops(count);
        wait_drained();
    endtask

    initial begin
        wipe_heap();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks under the reset configuration.
        queue_op(OP_ALLOC, 32'd100);
        queue_op(OP_MERGE);
        queue_op(OP_FREE, 0, AK_OBJECT, 32'd0);
        queue_op(OP_INIT);
        queue_op(OP_ALLOC, 32'd0);
        queue_op(OP_ALLOC, 32'd1, AK_OBJECT);
        queue_op(OP_ALLOC, 32'h1001, AK_STRING);
        queue_op(OP_ALLOC, 32'h2000, AK_ARRAY);
        queue_op(OP_ALLOC, 32'd5, AK_SPARE);
        queue_op(OP_FREE, 0, AK_OBJECT, 0, 1'b1);
        queue_op(OP_FREE, 0, AK_OBJECT, 32'd0);
        queue_op(OP_FREE, 0, AK_OBJECT, 32'd0);
        queue_op(OP_ALLOC, 32'hFFFF_FFFF, AK_ARRAY);
        queue_op(OP_ALLOC, 32'hFFFF_F001);
        queue_op(OP_MERGE);
        queue_op(OP_INIT);
        queue_op(OP_ALLOC, REGION_BYTES_RESET);
        queue_op(OP_ALLOC, 32'd1);
        queue_op(OP_FREE, 0, AK_OBJECT, 32'd0);
        queue_op(OP_MERGE);
        queue_op(OP_FREE, 32'hFFFF_FFFF, AK_SPARE, 32'hFFFF_FFFF);
        wait_drained();

        run_phase(32'd0, REGION_BYTES_RESET, ALIGN_LOG2_RESET, 110);
        run_phase(32'hFFFF_0000, 32'h0001_0000, 5'd0, 100);
        run_phase(32'd0, 32'hFFFF_FFFF, 5'd31, 100);
        run_phase(32'h1234_5000, 32'd0, 5'd16, 30);

        // A small region that wraps past the top of the address space fills the table.
        steady = 1'b1;
        write_reg(CFG_REGION_BASE, 32'hFFFF_F000);
        write_reg(CFG_REGION_BYTES, 32'h0000_2000);
        write_reg(CFG_ALIGN_LOG2, 32'd4);
        queue_op(OP_INIT);
        for (int n = 0; n < 70; n++) queue_op(OP_ALLOC, $urandom_range(1, 32), 2'(n % 4));
        queue_random_ops(80);
        wait_drained();
        steady = 1'b0;

        run_phase($urandom, $urandom_range(1, 32'h0040_0000), 5'($urandom_range(0, 20)),
                  120);

        repeat (200) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ffbta_pkg.sv
rtl/core/ffbta_table_ram.sv
rtl/core/ffbta_engine.sv
rtl/core/first_fit_block_table_allocator_top.sv
dv/tb.sv
